>>> rtl/core/tsc_pkg.sv
// Shared types and constants of the clock time set controller.
package tsc_pkg;

  localparam int NUM_BUTTONS = 4;
  localparam int NUM_FIELDS  = 6;

  localparam int YEAR_W   = 16;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int HOUR_W   = 5;
  localparam int MINUTE_W = 6;
  localparam int SECOND_W = 6;
  localparam int FIELD_W  = 3;

  localparam int DEB_W   = 6;
  localparam int BLINK_W = 10;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_MS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLINK_HALF_MS = 2'd1;

  localparam logic [DEB_W-1:0]   DEBOUNCE_RST = 6'd30;
  localparam logic [BLINK_W-1:0] BLINK_RST    = 10'd600;
  localparam logic [DEB_W-1:0]   TICKS_MAX    = 6'd63;

  localparam int BTN_SET    = 0;
  localparam int BTN_UP     = 1;
  localparam int BTN_OK     = 2;
  localparam int BTN_CANCEL = 3;

  localparam logic [MONTH_W-1:0]  MONTHS_PER_YEAR  = 4'd12;
  localparam logic [DAY_W-1:0]    DAYS_MAX         = 5'd31;
  localparam logic [HOUR_W:0]     HOURS_PER_DAY    = 6'd24;
  localparam logic [MINUTE_W:0]   MINUTES_PER_HOUR = 7'd60;
  localparam logic [SECOND_W:0]   SECONDS_PER_MIN  = 7'd60;

  typedef enum logic [FIELD_W-1:0] {
    FLD_NONE   = 3'd0,
    FLD_YEAR   = 3'd1,
    FLD_MONTH  = 3'd2,
    FLD_DAY    = 3'd3,
    FLD_HOUR   = 3'd4,
    FLD_MINUTE = 3'd5,
    FLD_SECOND = 3'd6
  } field_t;

  typedef struct packed {
    logic [YEAR_W-1:0]   year;
    logic [MONTH_W-1:0]  month;
    logic [DAY_W-1:0]    day;
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
    logic [SECOND_W-1:0] second;
  } time_t;

endpackage

>>> rtl/core/tsc_in_if.sv
// Input word channel: button levels and current clock time.
interface tsc_in_if import tsc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                set_level;
  logic                up_level;
  logic                ok_level;
  logic                cancel_level;
  logic [YEAR_W-1:0]   rtc_year;
  logic [MONTH_W-1:0]  rtc_month;
  logic [DAY_W-1:0]    rtc_day;
  logic [HOUR_W-1:0]   rtc_hour;
  logic [MINUTE_W-1:0] rtc_minute;
  logic [SECOND_W-1:0] rtc_second;

  modport source (
    output valid, set_level, up_level, ok_level, cancel_level,
           rtc_year, rtc_month, rtc_day, rtc_hour, rtc_minute, rtc_second,
    input  ready
  );
  modport sink (
    input  valid, set_level, up_level, ok_level, cancel_level,
           rtc_year, rtc_month, rtc_day, rtc_hour, rtc_minute, rtc_second,
    output ready
  );
endinterface

>>> rtl/core/tsc_out_if.sv
// Result word channel: time to show, blanking and commit.
interface tsc_out_if import tsc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [YEAR_W-1:0]   show_year;
  logic [MONTH_W-1:0]  show_month;
  logic [DAY_W-1:0]    show_day;
  logic [HOUR_W-1:0]   show_hour;
  logic [MINUTE_W-1:0] show_minute;
  logic [SECOND_W-1:0] show_second;
  logic [FIELD_W-1:0]  blank_field;
  logic                setting_active;
  logic                commit;

  modport source (
    output valid, show_year, show_month, show_day, show_hour, show_minute,
           show_second, blank_field, setting_active, commit,
    input  ready
  );
  modport sink (
    input  valid, show_year, show_month, show_day, show_hour, show_minute,
           show_second, blank_field, setting_active, commit,
    output ready
  );
endinterface

>>> rtl/core/tsc_cfg_if.sv
// Configuration write channel.
interface tsc_cfg_if import tsc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/core/clock_time_set_controller.sv
// Clock time set controller: debounced buttons, field editing, blink and commit.
//
// One word is one millisecond tick. A word enters an input register, passes through one
// level of debounce, edit and blink logic, and lands in the result register; a new word is
// taken every cycle, and the only limit on rate is the result register being drained.
// Configuration writes are always ready and take effect at once.
module clock_time_set_controller import tsc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  tsc_in_if.sink    in_ch,
  tsc_out_if.source out_ch,
  tsc_cfg_if.sink   cfg_ch
);

  logic [DEB_W-1:0]   debounce_r;
  logic [BLINK_W-1:0] blink_half_r;

  logic  in_v_r;
  logic  [NUM_BUTTONS-1:0] lvl_r;
  time_t rtc_r;

  logic   in_setting_r, in_setting_nxt;
  field_t sel_r, sel_nxt;
  time_t  edit_r, edit_nxt;
  logic   [NUM_BUTTONS-1:0] stable_r, stable_nxt;
  logic   [DEB_W-1:0] ticks_r [NUM_BUTTONS];
  logic   [DEB_W-1:0] ticks_nxt [NUM_BUTTONS];
  logic   visible_r, visible_nxt;
  logic   [BLINK_W-1:0] blink_ticks_r, blink_ticks_nxt;

  logic   out_v_r;
  time_t  show_r, show_nxt;
  field_t blank_r, blank_nxt;
  logic   out_set_r;
  logic   commit_r, commit_nxt;

  logic proceed;
  logic [NUM_BUTTONS-1:0] chg_raw, sample, take;
  logic set_press, up_press, ok_press, cancel_press, entered;
  logic [BLINK_W:0]   blink_sum;
  logic [BLINK_W-1:0] blink_limit;
  logic [MONTH_W-1:0] month_mod;
  logic [DAY_W-1:0]   day_mod;
  logic [HOUR_W:0]    hour_inc;
  logic [MINUTE_W:0]  minute_inc;
  logic [SECOND_W:0]  second_inc;

  assign proceed     = in_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready = !in_v_r || proceed;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r   <= DEBOUNCE_RST;
      blink_half_r <= BLINK_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_DEBOUNCE_MS:   debounce_r   <= cfg_ch.data[DEB_W-1:0];
        REG_BLINK_HALF_MS: blink_half_r <= cfg_ch.data[BLINK_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      lvl_r[BTN_SET]    <= in_ch.set_level;
      lvl_r[BTN_UP]     <= in_ch.up_level;
      lvl_r[BTN_OK]     <= in_ch.ok_level;
      lvl_r[BTN_CANCEL] <= in_ch.cancel_level;
      rtc_r <= '{in_ch.rtc_year, in_ch.rtc_month, in_ch.rtc_day,
                 in_ch.rtc_hour, in_ch.rtc_minute, in_ch.rtc_second};
    end
  end

  // debouncers
  always_comb begin
    for (int b = 0; b < NUM_BUTTONS; b++) begin
      chg_raw[b] = (ticks_r[b] >= debounce_r) && (lvl_r[b] != stable_r[b]);
    end
    cancel_press        = in_setting_r && chg_raw[BTN_CANCEL] && !lvl_r[BTN_CANCEL];
    sample[BTN_SET]     = 1'b1;
    sample[BTN_CANCEL]  = in_setting_r;
    sample[BTN_UP]      = in_setting_r && !cancel_press;
    sample[BTN_OK]      = in_setting_r && !cancel_press;
    for (int b = 0; b < NUM_BUTTONS; b++) begin
      take[b]       = sample[b] && chg_raw[b];
      stable_nxt[b] = take[b] ? lvl_r[b] : stable_r[b];
      if (take[b]) begin
        ticks_nxt[b] = '0;
      end else if (ticks_r[b] == TICKS_MAX) begin
        ticks_nxt[b] = ticks_r[b];
      end else begin
        ticks_nxt[b] = ticks_r[b] + 1'b1;
      end
    end
    set_press = take[BTN_SET] && !lvl_r[BTN_SET];
    up_press  = take[BTN_UP] && !lvl_r[BTN_UP];
    ok_press  = take[BTN_OK] && !lvl_r[BTN_OK];
  end

  // field editing
  always_comb begin
    month_mod  = (edit_r.month >= MONTHS_PER_YEAR) ? edit_r.month - MONTHS_PER_YEAR
                                                   : edit_r.month;
    day_mod    = (edit_r.day == DAYS_MAX) ? '0 : edit_r.day;
    hour_inc   = {1'b0, edit_r.hour} + 1'b1;
    minute_inc = {1'b0, edit_r.minute} + 1'b1;
    second_inc = {1'b0, edit_r.second} + 1'b1;
    if (hour_inc >= HOURS_PER_DAY)      hour_inc   = hour_inc - HOURS_PER_DAY;
    if (minute_inc >= MINUTES_PER_HOUR) minute_inc = minute_inc - MINUTES_PER_HOUR;
    if (second_inc >= SECONDS_PER_MIN)  second_inc = second_inc - SECONDS_PER_MIN;

    in_setting_nxt = in_setting_r;
    sel_nxt        = sel_r;
    edit_nxt       = edit_r;
    commit_nxt     = 1'b0;
    entered        = set_press && !in_setting_r;

    if (entered) begin
      in_setting_nxt = 1'b1;
      sel_nxt        = FLD_YEAR;
      edit_nxt       = rtc_r;
    end

    if (in_setting_r) begin
      if (cancel_press) begin
        in_setting_nxt = 1'b0;
        sel_nxt        = FLD_YEAR;
      end
      if (up_press) begin
        case (sel_r)
          FLD_YEAR:   edit_nxt.year   = edit_r.year + 1'b1;
          FLD_MONTH:  edit_nxt.month  = month_mod + 1'b1;
          FLD_DAY:    edit_nxt.day    = day_mod + 1'b1;
          FLD_HOUR:   edit_nxt.hour   = hour_inc[HOUR_W-1:0];
          FLD_MINUTE: edit_nxt.minute = minute_inc[MINUTE_W-1:0];
          FLD_SECOND: edit_nxt.second = second_inc[SECOND_W-1:0];
          default: ;
        endcase
      end
      if (ok_press) begin
        if (sel_r < FLD_SECOND) begin
          sel_nxt = field_t'(sel_r + 1'b1);
        end else begin
          commit_nxt     = 1'b1;
          in_setting_nxt = 1'b0;
          sel_nxt        = FLD_YEAR;
        end
      end
    end
  end

  // blink and result
  always_comb begin
    blink_limit     = (blink_half_r == '0) ? BLINK_W'(1) : blink_half_r;
    blink_sum       = {1'b0, blink_ticks_r} + 1'b1;
    visible_nxt     = visible_r;
    blink_ticks_nxt = blink_ticks_r;
    if (!in_setting_nxt || entered) begin
      visible_nxt     = 1'b1;
      blink_ticks_nxt = '0;
    end else if (blink_sum >= {1'b0, blink_limit}) begin
      visible_nxt     = !visible_r;
      blink_ticks_nxt = '0;
    end else begin
      blink_ticks_nxt = blink_sum[BLINK_W-1:0];
    end

    show_nxt  = (in_setting_nxt || commit_nxt) ? edit_nxt : rtc_r;
    blank_nxt = (in_setting_nxt && !visible_nxt) ? sel_nxt : FLD_NONE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_setting_r  <= 1'b0;
      sel_r         <= FLD_YEAR;
      edit_r        <= '0;
      stable_r      <= '1;
      for (int b = 0; b < NUM_BUTTONS; b++) ticks_r[b] <= '0;
      visible_r     <= 1'b1;
      blink_ticks_r <= '0;
    end else if (proceed) begin
      in_setting_r  <= in_setting_nxt;
      sel_r         <= sel_nxt;
      edit_r        <= edit_nxt;
      stable_r      <= stable_nxt;
      for (int b = 0; b < NUM_BUTTONS; b++) ticks_r[b] <= ticks_nxt[b];
      visible_r     <= visible_nxt;
      blink_ticks_r <= blink_ticks_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (proceed) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proceed) begin
      show_r    <= show_nxt;
      blank_r   <= blank_nxt;
      out_set_r <= in_setting_nxt;
      commit_r  <= commit_nxt;
    end
  end

  assign out_ch.valid          = out_v_r;
  assign out_ch.show_year      = show_r.year;
  assign out_ch.show_month     = show_r.month;
  assign out_ch.show_day       = show_r.day;
  assign out_ch.show_hour      = show_r.hour;
  assign out_ch.show_minute    = show_r.minute;
  assign out_ch.show_second    = show_r.second;
  assign out_ch.blank_field    = blank_r;
  assign out_ch.setting_active = out_set_r;
  assign out_ch.commit         = commit_r;

  a_commit_leaves: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && commit_r |-> !out_set_r && blank_r == FLD_NONE)
    else $error("commit word still in setting mode");

  a_blank_only_setting: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && blank_r != FLD_NONE |-> out_set_r)
    else $error("field blanked outside setting mode");

  a_idle_blink_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !in_setting_r |-> visible_r && blink_ticks_r == '0)
    else $error("blink state not cleared outside setting mode");

  a_enter_at_year: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_setting_r) |-> sel_r == FLD_YEAR && visible_r)
    else $error("setting mode entered at wrong field");

  a_word_moves: assert property (@(posedge clk) disable iff (!rst_n)
    proceed |=> out_v_r)
    else $error("processed word lost");

endmodule
